// File: rtl/ttg_pkg.sv
// Package for the triangle tangent generator: widths, state type and
// saturation constants. No dependencies.
`timescale 1ns / 1ps
package ttg_pkg;

    // fraction bits of the tangent components
    localparam int OUT_FRAC_BITS = 14;

    localparam int IDX_W = 32;          // vertex index
    localparam int COORD_W = 32;        // Q16.16 input coordinate
    localparam int OP_W = COORD_W + 1;  // edge / uv delta
    localparam int ACC_W = 2 * OP_W + 2; // a*b - c*d accumulator
    localparam int MAG_W = ACC_W - 1;   // magnitude of a component
    localparam int M_W = 31;            // normalized magnitude
    localparam int SUM_W = 64;          // sum of squares
    localparam int LEN_W = 32;          // vector length
    localparam int NUM_W = LEN_W + OUT_FRAC_BITS; // dividend and quotient
    localparam int TAN_W = 16;          // tangent component
    localparam int MAC_CNT_W = $clog2(OP_W);
    localparam int ROOT_CNT_W = $clog2(SUM_W / 2);
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [NUM_W-1:0] SAT_POS = NUM_W'(32767);
    localparam logic [NUM_W-1:0] SAT_NEG = NUM_W'(32768);
    localparam logic [TAN_W-1:0] TAN_MAX = 16'h7FFF;
    localparam logic [TAN_W-1:0] TAN_MIN = 16'h8000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_NORM,
        ST_SQR_GO,
        ST_SQR_WAIT,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } t_state;

endpackage

// File: rtl/ttg_serial_mac.sv
// Bit-serial multiply-accumulate: result = a*b - c*d, one multiplier bit
// per cycle, two's complement operands. Depends on ttg_pkg.
`timescale 1ns / 1ps
module ttg_serial_mac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ttg_pkg::OP_W-1:0]    i_a,
    input  logic [ttg_pkg::OP_W-1:0]    i_b,
    input  logic [ttg_pkg::OP_W-1:0]    i_c,
    input  logic [ttg_pkg::OP_W-1:0]    i_d,
    output logic                        o_done,
    output logic [ttg_pkg::ACC_W-1:0]   o_result
);

    localparam int EXT_W = ttg_pkg::ACC_W - ttg_pkg::OP_W;

    logic                           r_busy;
    logic                           r_second;
    logic                           r_done;
    logic [ttg_pkg::MAC_CNT_W-1:0]  r_cnt;
    logic [ttg_pkg::ACC_W-1:0]      r_mcand;
    logic [ttg_pkg::OP_W-1:0]       r_mplier;
    logic [ttg_pkg::OP_W-1:0]       r_c;
    logic [ttg_pkg::OP_W-1:0]       r_d;
    logic [ttg_pkg::ACC_W-1:0]      r_acc;
    logic [ttg_pkg::ACC_W-1:0]      n_acc;
    logic [ttg_pkg::ACC_W-1:0]      term;
    logic                           last_bit;

    // sign bit of the multiplier carries negative weight; second product subtracts
    always_comb begin
        last_bit = (r_cnt == ttg_pkg::MAC_CNT_W'(ttg_pkg::OP_W - 1));
        term = r_mplier[0] ? r_mcand : '0;
        n_acc = (last_bit ^ r_second) ? r_acc - term : r_acc + term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_second <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_second <= 1'b0;
                r_cnt <= '0;
                r_acc <= '0;
                r_mcand <= {{EXT_W{i_a[ttg_pkg::OP_W-1]}}, i_a};
                r_mplier <= i_b;
                r_c <= i_c;
                r_d <= i_d;
            end else if (r_busy) begin
                r_acc <= n_acc;
                if (last_bit) begin
                    r_cnt <= '0;
                    if (!r_second) begin
                        r_second <= 1'b1;
                        r_mcand <= {{EXT_W{r_c[ttg_pkg::OP_W-1]}}, r_c};
                        r_mplier <= r_d;
                    end else begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_mcand <= {r_mcand[ttg_pkg::ACC_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[ttg_pkg::OP_W-1:1]};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_result = r_acc;

endmodule

// File: rtl/ttg_isqrt.sv
// Integer square root, one result bit per cycle (digit-by-digit method).
// Depends on ttg_pkg.
`timescale 1ns / 1ps
module ttg_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ttg_pkg::SUM_W-1:0]   i_value,
    output logic                        o_done,
    output logic [ttg_pkg::LEN_W-1:0]   o_root
);

    logic                               r_busy;
    logic                               r_done;
    logic [ttg_pkg::ROOT_CNT_W-1:0]     r_cnt;
    logic [ttg_pkg::SUM_W-1:0]          r_n;
    logic [ttg_pkg::SUM_W-1:0]          r_r;
    logic [ttg_pkg::SUM_W-1:0]          r_bit;
    logic [ttg_pkg::SUM_W-1:0]          trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_n <= i_value;
                r_r <= '0;
                r_bit <= {2'b01, {(ttg_pkg::SUM_W - 2){1'b0}}};
            end else if (r_busy) begin
                // try the next bit pair
                if (r_n >= trial) begin
                    r_n <= r_n - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ttg_pkg::LEN_W-1:0];

endmodule

// File: rtl/ttg_divider.sv
// Restoring divider, one quotient bit per cycle, for the rounded
// quotient (m * 2^F + L/2) / L. Depends on ttg_pkg.
`timescale 1ns / 1ps
module ttg_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ttg_pkg::M_W-1:0]     i_mag,
    input  logic [ttg_pkg::LEN_W-1:0]   i_len,
    output logic                        o_done,
    output logic [ttg_pkg::NUM_W-1:0]   o_quot
);

    logic                               r_busy;
    logic                               r_done;
    logic [ttg_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [ttg_pkg::NUM_W-1:0]          r_num;
    logic [ttg_pkg::LEN_W-1:0]          r_rem;
    logic [ttg_pkg::LEN_W-1:0]          r_den;
    logic [ttg_pkg::LEN_W:0]            shifted;
    logic                               ge;
    logic [ttg_pkg::NUM_W-1:0]          dividend;

    always_comb begin
        dividend = ttg_pkg::NUM_W'({i_mag, {ttg_pkg::OUT_FRAC_BITS{1'b0}}})
                 + ttg_pkg::NUM_W'(i_len >> 1);
        shifted = {r_rem, r_num[ttg_pkg::NUM_W-1]};
        ge = (shifted >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_num <= dividend;
                r_rem <= '0;
                r_den <= i_len;
            end else if (r_busy) begin
                // remainder stays below the divisor
                r_rem <= ge ? ttg_pkg::LEN_W'(shifted - {1'b0, r_den})
                            : shifted[ttg_pkg::LEN_W-1:0];
                r_num <= {r_num[ttg_pkg::NUM_W-2:0], ge};
                if (r_cnt == ttg_pkg::DIV_CNT_W'(ttg_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// File: rtl/triangle_tangent_generator.sv
// Top level of the per-face tangent generator: corner storage, sequencer,
// normalization and output register. Depends on ttg_pkg, ttg_serial_mac,
// ttg_isqrt and ttg_divider.
//
// Usage: corners enter on the s_axis channel, one transaction per corner;
// s_axis_tlast marks the last corner of a mesh and restarts the corner
// count (a partial triangle is dropped). The first two corners of a
// triangle are only stored; the third corner starts the computation
// and the channel stays not-ready until the third result has been
// loaded into the output register.
// Per triangle: four a*b-c*d jobs on the bit-serial MAC, one-bit
// normalizing shifts, two square jobs on the MAC, the square root and
// three divisions, then three results. The MAC dominates. A degenerate
// triangle skips the square jobs, the root and the divisions.
// m_axis carries one result per transaction; a stalled receiver holds the
// output register and the sequencer waits, so no result is lost or
// repeated. Reset clears the corner count, the sequencer and the output
// valid.
`timescale 1ns / 1ps
module triangle_tangent_generator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // corner_index, pos_x, pos_y, pos_z, tex_u, tex_v (32 bits each)
    input  logic [191:0]    s_axis_tdata,
    input  logic            s_axis_tlast,   // end_of_mesh
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // vertex_index (32), tangent_x, tangent_y, tangent_z (16 each)
    output logic [79:0]     m_axis_tdata,
    output logic            m_axis_tuser,   // degenerate
    output logic            m_axis_tlast    // last_of_triangle
);

    localparam int CW = ttg_pkg::COORD_W;
    localparam int OW = ttg_pkg::OP_W;

    ttg_pkg::t_state r_state;
    ttg_pkg::t_state n_state;

    // held corners
    logic [1:0]                 r_phase;
    logic [ttg_pkg::IDX_W-1:0]  r_hidx [0:1];
    logic [CW-1:0]              r_p0 [0:2];
    logic [CW-1:0]              r_p1 [0:2];
    logic [CW-1:0]              r_t0u;
    logic [CW-1:0]              r_t0v;
    logic [CW-1:0]              r_t1u;
    logic [CW-1:0]              r_t1v;
    logic [ttg_pkg::IDX_W-1:0]  r_idx2;

    // triangle operands
    logic [OW-1:0]              r_e1 [0:2];
    logic [OW-1:0]              r_e2 [0:2];
    logic [OW-1:0]              r_du1;
    logic [OW-1:0]              r_dv1;
    logic [OW-1:0]              r_du2;
    logic [OW-1:0]              r_dv2;

    // results of the sequence
    logic [1:0]                 r_job;
    logic                       r_det_nz;
    logic                       r_degen;
    logic [ttg_pkg::MAG_W-1:0]  r_mag [0:2];
    logic                       r_neg [0:2];
    logic [ttg_pkg::SUM_W-1:0]  r_sum;
    logic [ttg_pkg::LEN_W-1:0]  r_len;
    logic [ttg_pkg::TAN_W-1:0]  r_tan [0:2];

    // output register
    logic                       r_ovalid;
    logic [79:0]                r_odata;
    logic                       r_odeg;
    logic                       r_olast;

    // input fields
    logic [ttg_pkg::IDX_W-1:0]  in_idx;
    logic [CW-1:0]              in_pos [0:2];
    logic [CW-1:0]              in_u;
    logic [CW-1:0]              in_v;
    logic                       in_acc;

    // unit handshakes
    logic                       mac_start;
    logic                       mac_done;
    logic [ttg_pkg::ACC_W-1:0]  mac_result;
    logic [OW-1:0]              mac_a;
    logic [OW-1:0]              mac_b;
    logic [OW-1:0]              mac_c;
    logic [OW-1:0]              mac_d;
    logic                       root_start;
    logic                       root_done;
    logic [ttg_pkg::LEN_W-1:0]  root_out;
    logic                       div_start;
    logic                       div_done;
    logic [ttg_pkg::NUM_W-1:0]  div_quot;
    logic                       emit_go;

    // normalization status
    logic                       any_hi;
    logic                       any_b30;
    logic                       all_zero;
    logic                       norm_degen;
    logic                       norm_ok;
    logic [ttg_pkg::ACC_W-1:0]  res_abs;
    logic [ttg_pkg::TAN_W-1:0]  tan_enc;

    assign in_idx = s_axis_tdata[31:0];
    assign in_pos[0] = s_axis_tdata[63:32];
    assign in_pos[1] = s_axis_tdata[95:64];
    assign in_pos[2] = s_axis_tdata[127:96];
    assign in_u = s_axis_tdata[159:128];
    assign in_v = s_axis_tdata[191:160];
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // normalization checks over the three magnitudes
    always_comb begin
        any_hi = 1'b0;
        any_b30 = 1'b0;
        all_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            any_hi = any_hi | (|r_mag[i][ttg_pkg::MAG_W-1:ttg_pkg::M_W]);
            any_b30 = any_b30 | r_mag[i][ttg_pkg::M_W-1];
            all_zero = all_zero & ~(|r_mag[i]);
        end
        norm_degen = !r_det_nz || all_zero;
        norm_ok = !any_hi && any_b30;
    end

    assign res_abs = mac_result[ttg_pkg::ACC_W-1] ? ('0 - mac_result) : mac_result;

    // MAC operand select
    always_comb begin
        mac_a = r_du1;
        mac_b = r_dv2;
        mac_c = r_du2;
        mac_d = r_dv1;
        if (r_state == ttg_pkg::ST_SQR_GO) begin
            if (r_job == 2'd0) begin
                mac_a = OW'(r_mag[0][ttg_pkg::M_W-1:0]);
                mac_b = mac_a;
                mac_c = OW'(r_mag[1][ttg_pkg::M_W-1:0]);
                mac_d = '0 - mac_c;
            end else begin
                mac_a = OW'(r_mag[2][ttg_pkg::M_W-1:0]);
                mac_b = mac_a;
                mac_c = '0;
                mac_d = '0;
            end
        end else if (r_job != 2'd0) begin
            mac_a = r_dv2;
            mac_b = r_e1[r_job - 2'd1];
            mac_c = r_dv1;
            mac_d = r_e2[r_job - 2'd1];
        end
    end

    // quotient to signed Q1.F, negated for a positive component, saturated
    always_comb begin
        if (!r_neg[r_job]) begin
            tan_enc = (div_quot > ttg_pkg::SAT_NEG) ? ttg_pkg::TAN_MIN
                    : ttg_pkg::TAN_W'('0 - div_quot[ttg_pkg::TAN_W-1:0]);
        end else begin
            tan_enc = (div_quot > ttg_pkg::SAT_POS) ? ttg_pkg::TAN_MAX
                    : div_quot[ttg_pkg::TAN_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ttg_pkg::ST_IDLE: begin
                if (in_acc && r_phase == 2'd2) n_state = ttg_pkg::ST_MUL_GO;
            end
            ttg_pkg::ST_MUL_GO: n_state = ttg_pkg::ST_MUL_WAIT;
            ttg_pkg::ST_MUL_WAIT: begin
                if (mac_done) begin
                    n_state = (r_job == 2'd3) ? ttg_pkg::ST_NORM : ttg_pkg::ST_MUL_GO;
                end
            end
            ttg_pkg::ST_NORM: begin
                if (norm_degen) n_state = ttg_pkg::ST_EMIT;
                else if (norm_ok) n_state = ttg_pkg::ST_SQR_GO;
            end
            ttg_pkg::ST_SQR_GO: n_state = ttg_pkg::ST_SQR_WAIT;
            ttg_pkg::ST_SQR_WAIT: begin
                if (mac_done) begin
                    n_state = (r_job == 2'd1) ? ttg_pkg::ST_ROOT_GO : ttg_pkg::ST_SQR_GO;
                end
            end
            ttg_pkg::ST_ROOT_GO: n_state = ttg_pkg::ST_ROOT_WAIT;
            ttg_pkg::ST_ROOT_WAIT: begin
                if (root_done) n_state = ttg_pkg::ST_DIV_GO;
            end
            ttg_pkg::ST_DIV_GO: n_state = ttg_pkg::ST_DIV_WAIT;
            ttg_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_job == 2'd2) ? ttg_pkg::ST_EMIT : ttg_pkg::ST_DIV_GO;
                end
            end
            ttg_pkg::ST_EMIT: begin
                if (emit_go && r_job == 2'd2) n_state = ttg_pkg::ST_IDLE;
            end
            default: n_state = ttg_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = (r_state == ttg_pkg::ST_IDLE);
        mac_start = (r_state == ttg_pkg::ST_MUL_GO) || (r_state == ttg_pkg::ST_SQR_GO);
        root_start = (r_state == ttg_pkg::ST_ROOT_GO);
        div_start = (r_state == ttg_pkg::ST_DIV_GO);
        emit_go = (r_state == ttg_pkg::ST_EMIT) && (!r_ovalid || m_axis_tready);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttg_pkg::ST_IDLE;
            r_phase <= 2'd0;
            r_job <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_phase <= (s_axis_tlast || r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
            end
            // job counter restarts at every phase change
            if ((r_state == ttg_pkg::ST_MUL_WAIT && mac_done)
                || (r_state == ttg_pkg::ST_SQR_WAIT && mac_done)
                || (r_state == ttg_pkg::ST_DIV_WAIT && div_done)
                || emit_go) begin
                r_job <= (n_state == r_state || n_state == ttg_pkg::ST_MUL_GO
                          || n_state == ttg_pkg::ST_SQR_GO
                          || n_state == ttg_pkg::ST_DIV_GO) ? r_job + 2'd1 : 2'd0;
            end
            if (emit_go) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // corner capture and operand setup
        if (in_acc) begin
            if (r_phase == 2'd0) begin
                r_hidx[0] <= in_idx;
                for (int i = 0; i < 3; i++) r_p0[i] <= in_pos[i];
                r_t0u <= in_u;
                r_t0v <= in_v;
            end else if (r_phase == 2'd1) begin
                r_hidx[1] <= in_idx;
                for (int i = 0; i < 3; i++) r_p1[i] <= in_pos[i];
                r_t1u <= in_u;
                r_t1v <= in_v;
            end else begin
                r_idx2 <= in_idx;
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= {r_p1[i][CW-1], r_p1[i]} - {r_p0[i][CW-1], r_p0[i]};
                    r_e2[i] <= {in_pos[i][CW-1], in_pos[i]} - {r_p0[i][CW-1], r_p0[i]};
                    r_tan[i] <= '0;
                end
                r_du1 <= {r_t1u[CW-1], r_t1u} - {r_t0u[CW-1], r_t0u};
                r_dv1 <= {r_t1v[CW-1], r_t1v} - {r_t0v[CW-1], r_t0v};
                r_du2 <= {in_u[CW-1], in_u} - {r_t0u[CW-1], r_t0u};
                r_dv2 <= {in_v[CW-1], in_v} - {r_t0v[CW-1], r_t0v};
                r_degen <= 1'b0;
            end
        end

        // determinant and components
        if (r_state == ttg_pkg::ST_MUL_WAIT && mac_done) begin
            if (r_job == 2'd0) begin
                r_det_nz <= |mac_result;
            end else begin
                r_neg[r_job - 2'd1] <= mac_result[ttg_pkg::ACC_W-1];
                r_mag[r_job - 2'd1] <= res_abs[ttg_pkg::MAG_W-1:0];
            end
        end

        // one-bit normalizing shifts
        if (r_state == ttg_pkg::ST_NORM) begin
            if (norm_degen) begin
                r_degen <= 1'b1;
            end else if (any_hi) begin
                for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
            end else if (!any_b30) begin
                for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
            end
        end

        // sum of squares
        if (r_state == ttg_pkg::ST_SQR_WAIT && mac_done) begin
            if (r_job == 2'd0) r_sum <= mac_result[ttg_pkg::SUM_W-1:0];
            else r_sum <= r_sum + mac_result[ttg_pkg::SUM_W-1:0];
        end

        if (root_done) r_len <= root_out;

        if (r_state == ttg_pkg::ST_DIV_WAIT && div_done) r_tan[r_job] <= tan_enc;

        // result load
        if (emit_go) begin
            r_odata[79:32] <= {r_tan[2], r_tan[1], r_tan[0]};
            case (r_job)
                2'd0: r_odata[31:0] <= r_hidx[0];
                2'd1: r_odata[31:0] <= r_hidx[1];
                default: r_odata[31:0] <= r_idx2;
            endcase
            r_odeg <= r_degen;
            r_olast <= (r_job == 2'd2);
        end
    end

    ttg_serial_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mac_start),
        .i_a      (mac_a),
        .i_b      (mac_b),
        .i_c      (mac_c),
        .i_d      (mac_d),
        .o_done   (mac_done),
        .o_result (mac_result)
    );

    ttg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (r_sum),
        .o_done  (root_done),
        .o_root  (root_out)
    );

    ttg_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (r_mag[r_job][ttg_pkg::M_W-1:0]),
        .i_len   (r_len),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_odeg;
    assign m_axis_tlast = r_olast;

endmodule
